// ===== rtl/wpd_pkg.sv =====
// Shared types and constants for the WAV PCM stream decoder.
// No dependencies; imported by wpd_sample_fmt and wav_pcm_stream_decoder_core.
package wpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_e;

  // event kinds (tuser)
  localparam logic [1:0] EV_SAMPLE = 2'd0;
  localparam logic [1:0] EV_FORMAT = 2'd1;
  localparam logic [1:0] EV_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_SHORT   = 3'd0;
  localparam logic [2:0] ERR_SIG     = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM = 3'd2;
  localparam logic [2:0] ERR_WIDTH   = 3'd3;
  localparam logic [2:0] ERR_NO_DATA = 3'd4;

  // header layout
  localparam logic [5:0] OFF_RIFF_END = 6'd3;
  localparam logic [5:0] OFF_WAVE     = 6'd8;
  localparam logic [5:0] OFF_WAVE_END = 6'd11;
  localparam logic [5:0] OFF_FMT      = 6'd20;
  localparam logic [5:0] OFF_FMT_END  = 6'd21;
  localparam logic [5:0] OFF_CHAN     = 6'd22;
  localparam logic [5:0] OFF_CHAN_END = 6'd23;
  localparam logic [5:0] OFF_RATE     = 6'd24;
  localparam logic [5:0] OFF_RATE_END = 6'd27;
  localparam logic [5:0] OFF_BITS     = 6'd34;
  localparam logic [5:0] OFF_HDR_LAST = 6'd35;
  localparam logic [5:0] HDR_LEN      = 6'd36;

  localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [7:0]  SIGN_FLIP  = 8'h80;

  localparam logic [2:0] CHUNK_HDR_LAST = 3'd7;

  localparam int TDATA_W = 144;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_value;
    logic [15:0] channel_index;
    logic        last;
    logic [2:0]  error_code;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [5:0]  sample_bits;
    logic [31:0] data_bytes;
  } result_t;

endpackage

// ===== rtl/wpd_sample_fmt.sv =====
// Little-endian sample word to left-justified signed Q1.31.
// Depends on wpd_pkg.
module wpd_sample_fmt
  import wpd_pkg::*;
(
  input  logic [31:0] accum_i,  // assembled sample bytes, first byte lowest
  input  logic [2:0]  bpp_i,    // bytes per sample, 1..4
  output logic [31:0] sample_o
);

  always_comb begin
    case (bpp_i)
      3'd1:    sample_o = {accum_i[7:0] ^ SIGN_FLIP, 24'd0};  // unsigned 8-bit
      3'd2:    sample_o = {accum_i[15:0], 16'd0};
      3'd3:    sample_o = {accum_i[23:0], 8'd0};
      default: sample_o = accum_i;
    endcase
  end

endmodule

// ===== rtl/wav_pcm_stream_decoder_core.sv =====
// WAV PCM stream decoder top level: header capture, chunk walk, sample assembly.
// Depends on wpd_pkg and wpd_sample_fmt.
//
//  channel  dir  tdata                                   tlast        tuser
//  s_axis   in   data_byte                               stream_end   file_start
//  m_axis   out  sample/format/error fields (see port)   last_sample  event_kind
//
// One byte is taken per cycle; the result it causes (if any) appears in the
// output register on the next cycle. All parsing is one pass of logic between
// the parser state and the output register.
// rst_ni clears the parser to the header phase; file_start does the same in-band.
// Input stalls only while a result sits in the output register and m_axis_tready_i
// is low.
module wav_pcm_stream_decoder_core
  import wpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] data_byte
  input  logic               s_axis_tlast_i,   // stream_end
  input  logic               s_axis_tuser_i,   // file_start
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [31:0] sample_value, [47:32] channel_index, [50:48] error_code,
  // [82:51] rate_hz, [98:83] channel_count, [104:99] sample_bits,
  // [136:105] data_bytes, [143:137] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tlast_o,   // last_sample
  output logic [1:0]         m_axis_tuser_o    // event_kind
);

  phase_e      phase_q, phase_d;
  logic [5:0]  off_q, off_d;
  logic        sig_ok_q, sig_ok_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] left_q, left_d;
  logic [31:0] accum_q, accum_d;
  logic [1:0]  bis_q, bis_d;
  logic [15:0] chcnt_q, chcnt_d;
  logic [2:0]  fbc_q, fbc_d;

  logic        out_valid_q;
  result_t     out_q;
  result_t     res;
  logic        emit;

  logic        in_fire;
  logic [7:0]  b;
  logic        end_in;

  // state as seen by this byte (file_start restarts the parser first)
  phase_e      c_phase;
  logic [5:0]  c_off;
  logic        c_sig;
  logic [15:0] c_fmt, c_chan, c_bits, c_chcnt;
  logic [31:0] c_rate, c_tag, c_len, c_skip, c_left, c_accum;
  logic [1:0]  c_bis;
  logic [2:0]  c_fbc;

  logic        hdr_last, chk_pass;
  logic [2:0]  chk_code;
  logic [15:0] bits_full;
  logic [31:0] len_full, skip_dec, left_dec, accum_full;
  logic        chunk_done, is_data, sample_done, data_last;
  logic [2:0]  bpp, k_inc;
  logic [16:0] chcnt_inc;
  logic        ch_wrap;
  logic [31:0] sample_val;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign end_in          = s_axis_tlast_i;

  always_comb begin
    if (s_axis_tuser_i) begin
      c_phase = PH_HEADER; c_off = '0; c_sig = 1'b1; c_fmt = '0; c_chan = '0;
      c_rate = '0; c_bits = '0; c_tag = '0; c_len = '0; c_skip = '0; c_left = '0;
      c_accum = '0; c_bis = '0; c_chcnt = '0; c_fbc = '0;
    end else begin
      c_phase = phase_q; c_off = off_q; c_sig = sig_ok_q; c_fmt = fmt_q;
      c_chan = chan_q; c_rate = rate_q; c_bits = bits_q; c_tag = tag_q;
      c_len = len_q; c_skip = skip_q; c_left = left_q; c_accum = accum_q;
      c_bis = bis_q; c_chcnt = chcnt_q; c_fbc = fbc_q;
    end
  end

  // header check on the final header byte (its byte is the high bits byte)
  assign hdr_last  = (c_off == OFF_HDR_LAST);
  assign bits_full = {b, c_bits[7:0]};
  always_comb begin
    chk_pass = 1'b0;
    chk_code = ERR_NO_DATA;
    if (!c_sig) begin
      chk_code = ERR_SIG;
    end else if (c_fmt != PCM_FORMAT) begin
      chk_code = ERR_NOT_PCM;
    end else if (bits_full != 16'd8 && bits_full != 16'd16 &&
                 bits_full != 16'd24 && bits_full != 16'd32) begin
      chk_code = ERR_WIDTH;
    end else begin
      chk_pass = 1'b1;
    end
  end

  assign chunk_done = (c_fbc == CHUNK_HDR_LAST);
  assign len_full   = {b, c_len[23:0]};
  assign is_data    = (c_tag == TAG_DATA);
  assign skip_dec   = c_skip - 32'd1;
  assign left_dec   = c_left - 32'd1;
  assign data_last  = (left_dec == 32'd0) || end_in;

  always_comb begin
    accum_full = c_accum;
    case (c_bis)
      2'd0:    accum_full[7:0]   = c_accum[7:0]   | b;
      2'd1:    accum_full[15:8]  = c_accum[15:8]  | b;
      2'd2:    accum_full[23:16] = c_accum[23:16] | b;
      default: accum_full[31:24] = c_accum[31:24] | b;
    endcase
  end

  assign bpp         = c_bits[5:3];
  assign k_inc       = {1'b0, c_bis} + 3'd1;
  assign sample_done = (k_inc >= bpp);
  assign chcnt_inc   = {1'b0, c_chcnt} + 17'd1;
  assign ch_wrap     = (chcnt_inc >= {1'b0, c_chan});

  wpd_sample_fmt u_fmt (
    .accum_i  (accum_full),
    .bpp_i    (bpp),
    .sample_o (sample_val)
  );

  // next parser state
  always_comb begin
    phase_d = phase_q; off_d = off_q; sig_ok_d = sig_ok_q; fmt_d = fmt_q;
    chan_d = chan_q; rate_d = rate_q; bits_d = bits_q; tag_d = tag_q;
    len_d = len_q; skip_d = skip_q; left_d = left_q; accum_d = accum_q;
    bis_d = bis_q; chcnt_d = chcnt_q; fbc_d = fbc_q;
    if (in_fire) begin
      phase_d = c_phase; off_d = c_off; sig_ok_d = c_sig; fmt_d = c_fmt;
      chan_d = c_chan; rate_d = c_rate; bits_d = c_bits; tag_d = c_tag;
      len_d = c_len; skip_d = c_skip; left_d = c_left; accum_d = c_accum;
      bis_d = c_bis; chcnt_d = c_chcnt; fbc_d = c_fbc;
      case (c_phase)
        PH_HEADER: begin
          if (c_off <= OFF_RIFF_END) begin
            if (b != TAG_RIFF[{c_off[1:0], 3'b000} +: 8]) sig_ok_d = 1'b0;
          end else if (c_off inside {[OFF_WAVE:OFF_WAVE_END]}) begin
            if (b != TAG_WAVE[{c_off[1:0], 3'b000} +: 8]) sig_ok_d = 1'b0;
          end else if (c_off inside {[OFF_FMT:OFF_FMT_END]}) begin
            fmt_d[{c_off[0], 3'b000} +: 8] = b;
          end else if (c_off inside {[OFF_CHAN:OFF_CHAN_END]}) begin
            chan_d[{c_off[0], 3'b000} +: 8] = b;
          end else if (c_off inside {[OFF_RATE:OFF_RATE_END]}) begin
            rate_d[{c_off[1:0], 3'b000} +: 8] = b;
          end else if (c_off inside {[OFF_BITS:OFF_HDR_LAST]}) begin
            bits_d[{c_off[0], 3'b000} +: 8] = b;
          end
          off_d = c_off + 6'd1;
          if (hdr_last) begin
            off_d = HDR_LEN;
            if (chk_pass && !end_in) begin
              phase_d = PH_CHUNK;
              fbc_d   = '0;
            end else begin
              phase_d = PH_DONE;
            end
          end else if (end_in) begin
            phase_d = PH_DONE;
          end
        end
        PH_CHUNK: begin
          if (!c_fbc[2]) tag_d[{c_fbc[1:0], 3'b000} +: 8] = b;
          else           len_d[{c_fbc[1:0], 3'b000} +: 8] = b;
          fbc_d = c_fbc + 3'd1;
          if (chunk_done && is_data) begin
            left_d  = len_full;
            accum_d = '0;
            bis_d   = '0;
            chcnt_d = '0;
            phase_d = (len_full != 32'd0 && !end_in) ? PH_DATA : PH_DONE;
            tag_d   = '0;
            len_d   = '0;
          end else begin
            if (chunk_done) begin
              tag_d  = '0;
              skip_d = len_full;
              if (len_full != 32'd0) phase_d = PH_SKIP;
              else                   len_d   = '0;
            end
            if (end_in) phase_d = PH_DONE;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 32'd0) begin
            if (c_len[0]) skip_d  = 32'd1;   // pad byte after odd chunk
            else          phase_d = PH_CHUNK;
            len_d = '0;
          end
          if (end_in) phase_d = PH_DONE;
        end
        PH_DATA: begin
          left_d = left_dec;
          if (sample_done) begin
            chcnt_d = ch_wrap ? 16'd0 : chcnt_inc[15:0];
            accum_d = '0;
            bis_d   = '0;
          end else begin
            accum_d = accum_full;
            bis_d   = k_inc[1:0];
          end
          if (data_last) phase_d = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // result for this byte
  always_comb begin
    res  = '0;
    emit = 1'b0;
    case (c_phase)
      PH_HEADER: begin
        if (hdr_last) begin
          if (!chk_pass) begin
            emit = 1'b1; res.kind = EV_ERROR; res.error_code = chk_code;
          end else if (end_in) begin
            emit = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_NO_DATA;
          end
        end else if (end_in) begin
          emit = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_SHORT;
        end
      end
      PH_CHUNK: begin
        if (chunk_done && is_data) begin
          emit              = 1'b1;
          res.kind          = EV_FORMAT;
          res.rate_hz       = c_rate;
          res.channel_count = c_chan;
          res.sample_bits   = c_bits[5:0];
          res.data_bytes    = len_full;
        end else if (end_in) begin
          emit = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_NO_DATA;
        end
      end
      PH_SKIP: begin
        if (end_in) begin
          emit = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_NO_DATA;
        end
      end
      PH_DATA: begin
        if (sample_done) begin
          emit              = 1'b1;
          res.kind          = EV_SAMPLE;
          res.sample_value  = sample_val;
          res.channel_index = c_chcnt;
          res.last          = data_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      off_q    <= '0;
      sig_ok_q <= 1'b1;
      fmt_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      tag_q    <= '0;
      len_q    <= '0;
      skip_q   <= '0;
      left_q   <= '0;
      accum_q  <= '0;
      bis_q    <= '0;
      chcnt_q  <= '0;
      fbc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      sig_ok_q <= sig_ok_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      left_q   <= left_d;
      accum_q  <= accum_d;
      bis_q    <= bis_d;
      chcnt_q  <= chcnt_d;
      fbc_q    <= fbc_d;
      // ready means the held result is gone or leaves on this edge
      if (s_axis_tready_o) out_valid_q <= in_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {7'd0, out_q.data_bytes, out_q.sample_bits, out_q.channel_count,
                            out_q.rate_hz, out_q.error_code, out_q.channel_index,
                            out_q.sample_value};

endmodule
